FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the oriented-box overlap block.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a signal keeps its value in the cycle after a hold condition.
`define ASSERT_HOLD(label, clk, rst, cond, sig) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error("value changed while held");

`endif

FILE: rtl/core/obbsat_pkg.sv
// Shared constants for the oriented-box separating-axis overlap block.
// Depends on nothing.
`default_nettype none

package obbsat_pkg;
   // Default width of one packed component.
   localparam int COMPONENT_BITS_DEF = 16;
   // Register stages inside one axis lane.
   localparam int AXIS_STAGES = 4;
   // Candidate axes: three of each box and nine cross products.
   localparam int NUM_AXES = 15;
   // Vectors dotted with each axis: centre difference and six box axes.
   localparam int NUM_VECS = 7;
endpackage

`default_nettype wire

FILE: rtl/core/obbsat_axis.sv
// One candidate-axis lane: dot products, projections and the gap compare.
// Depends on obbsat_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module obbsat_axis
   import obbsat_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic signed [2*COMPONENT_BITS:0]      axis_l [3],
   input  wire logic signed [COMPONENT_BITS:0]        vec [NUM_VECS][3],
   input  wire logic        [COMPONENT_BITS-2:0]      half [NUM_VECS-1],
   output logic                                       axis_ok
);
   localparam int WL = 2*COMPONENT_BITS + 1;
   localparam int WP = WL + COMPONENT_BITS + 1;
   localparam int WD = WP + 2;
   localparam int WH = WD + COMPONENT_BITS - 1;
   localparam int WR = WH + 3;
   localparam int NH = NUM_VECS - 1;

   logic signed [WP-1:0] prod_ff [NUM_VECS][3];
   logic signed [WP-1:0] prod_in [NUM_VECS][3];
   logic [COMPONENT_BITS-2:0] half_d1_ff [NH];
   logic [COMPONENT_BITS-2:0] half_d2_ff [NH];
   logic [WD-1:0] dot_ff [NUM_VECS];
   logic [WD-1:0] dot_in [NUM_VECS];
   logic [WH-1:0] hp_ff [NH];
   logic [WH-1:0] hp_in [NH];
   logic [WR-1:0] dist_ff;
   logic [WR-1:0] dist_in;
   logic          ok_ff;
   logic          ok_in;
   logic [WR-1:0] reach;

   // Multiply each axis component by each vector component.
   always_comb begin
      for (int v = 0; v < NUM_VECS; v++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[v][k] = WP'(axis_l[k]) * WP'(vec[v][k]);
         end
      end
   end

   // Sum the three products and take the magnitude.
   always_comb begin
      logic signed [WD-1:0] s;
      s = '0;
      for (int v = 0; v < NUM_VECS; v++) begin
         s = WD'(prod_ff[v][0]) + WD'(prod_ff[v][1]) + WD'(prod_ff[v][2]);
         dot_in[v] = s[WD-1] ? WD'(-s) : WD'(s);
      end
   end

   // Weight each box-axis dot by its half length; scale the distance side.
   always_comb begin
      for (int m = 0; m < NH; m++) begin
         hp_in[m] = WH'(dot_ff[m+1]) * WH'(half_d2_ff[m]);
      end
      dist_in = WR'(dot_ff[0]) << (COMPONENT_BITS - 2);
   end

   // Add up the reach of both boxes and compare against the distance.
   always_comb begin
      reach = '0;
      for (int m = 0; m < NH; m++) begin
         reach = reach + WR'(hp_ff[m]);
      end
      ok_in = (dist_ff <= reach);
   end

   // Advance all lane stages together; hold on stall.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_in;
         half_d1_ff <= half;
         half_d2_ff <= half_d1_ff;
         dot_ff     <= dot_in;
         hp_ff      <= hp_in;
         dist_ff    <= dist_in;
         ok_ff      <= ok_in;
      end
   end

   assign axis_ok = ok_ff;

   `ASSERT_HOLD(a_ok_holds_on_stall, clock, reset, !en, ok_ff)
   `ASSERT_HOLD(a_dist_holds_on_stall, clock, reset, !en, dist_ff)
   `ASSERT_CLK(a_zero_dist_ok, clock, reset, en && dist_ff == '0 |=> ok_ff)
endmodule

`default_nettype wire

FILE: rtl/core/obb_separating_axis_overlap_top.sv
// Top level of the oriented-box overlap block: input stage, axis build, 15 axis lanes
// and the final reduction. Depends on obbsat_pkg, obbsat_axis and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Takes one pair of oriented boxes per word and returns one word per pair: overlap is 1
// when none of the 15 separating-axis candidates shows a gap. One pair enters every
// cycle unless req_stall is high; seven register stages (input register, axis build,
// four stages in each axis lane, output register) lie between an accepted pair and its
// result. While a result is waiting, rsp_stall freezes the whole pipeline and
// req_stall follows it.
module obb_separating_axis_overlap_top
   import obbsat_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [3*COMPONENT_BITS-1:0] req_a_center,
   input  wire logic [3*COMPONENT_BITS-1:0] req_a_axis_x,
   input  wire logic [3*COMPONENT_BITS-1:0] req_a_axis_y,
   input  wire logic [3*COMPONENT_BITS-1:0] req_a_axis_z,
   input  wire logic [3*COMPONENT_BITS-2:0] req_a_half_size,
   input  wire logic [3*COMPONENT_BITS-1:0] req_b_center,
   input  wire logic [3*COMPONENT_BITS-1:0] req_b_axis_x,
   input  wire logic [3*COMPONENT_BITS-1:0] req_b_axis_y,
   input  wire logic [3*COMPONENT_BITS-1:0] req_b_axis_z,
   input  wire logic [3*COMPONENT_BITS-2:0] req_b_half_size,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_overlap
);
   localparam int CB    = COMPONENT_BITS;
   localparam int WL    = 2*CB + 1;
   localparam int DEPTH = AXIS_STAGES + 3;

   logic en;
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;

   logic [3*CB-1:0] ac_ff, bc_ff;
   logic [3*CB-1:0] aax_ff [3];
   logic [3*CB-1:0] bax_ff [3];
   logic [3*CB-2:0] ah_ff, bh_ff;

   logic signed [CB-1:0] a_c [3][3];
   logic signed [CB-1:0] b_c [3][3];
   logic signed [WL-1:0] axes_in [NUM_AXES][3];
   logic signed [WL-1:0] axes_ff [NUM_AXES][3];
   logic signed [CB:0]   vec_in [NUM_VECS][3];
   logic signed [CB:0]   vec_ff [NUM_VECS][3];
   logic [CB-2:0]        half_in [NUM_VECS-1];
   logic [CB-2:0]        half_ff [NUM_VECS-1];
   logic [NUM_AXES-1:0]  ok;
   logic                 overlap_ff;

   // Move the pipeline unless a finished result is held.
   assign en        = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !en;

   // Shift valid bits along with the data.
   assign vld_in = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // Capture the input word.
   always_ff @(posedge clock) begin
      if (en) begin
         ac_ff     <= req_a_center;
         bc_ff     <= req_b_center;
         aax_ff[0] <= req_a_axis_x;
         aax_ff[1] <= req_a_axis_y;
         aax_ff[2] <= req_a_axis_z;
         bax_ff[0] <= req_b_axis_x;
         bax_ff[1] <= req_b_axis_y;
         bax_ff[2] <= req_b_axis_z;
         ah_ff     <= req_a_half_size;
         bh_ff     <= req_b_half_size;
      end
   end

   // Unpack components, form the centre difference and the candidate axes.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            a_c[i][k] = aax_ff[i][k*CB +: CB];
            b_c[i][k] = bax_ff[i][k*CB +: CB];
         end
      end
      for (int k = 0; k < 3; k++) begin
         vec_in[0][k] = (CB+1)'($signed(bc_ff[k*CB +: CB]))
                      - (CB+1)'($signed(ac_ff[k*CB +: CB]));
         half_in[k]   = ah_ff[k*CB +: CB-1];
         half_in[k+3] = bh_ff[k*CB +: CB-1];
      end
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            vec_in[1+i][k]  = (CB+1)'(a_c[i][k]);
            vec_in[4+i][k]  = (CB+1)'(b_c[i][k]);
            axes_in[i][k]   = WL'(a_c[i][k]);
            axes_in[3+i][k] = WL'(b_c[i][k]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            axes_in[6+3*i+j][0] = WL'(a_c[i][1]) * WL'(b_c[j][2])
                                - WL'(a_c[i][2]) * WL'(b_c[j][1]);
            axes_in[6+3*i+j][1] = WL'(a_c[i][2]) * WL'(b_c[j][0])
                                - WL'(a_c[i][0]) * WL'(b_c[j][2]);
            axes_in[6+3*i+j][2] = WL'(a_c[i][0]) * WL'(b_c[j][1])
                                - WL'(a_c[i][1]) * WL'(b_c[j][0]);
         end
      end
   end

   // Register the axes and the vectors they are dotted with.
   always_ff @(posedge clock) begin
      if (en) begin
         axes_ff <= axes_in;
         vec_ff  <= vec_in;
         half_ff <= half_in;
      end
   end

   // One lane per candidate axis.
   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      obbsat_axis #(
         .COMPONENT_BITS(COMPONENT_BITS)
      ) u_axis (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .axis_l (axes_ff[g]),
         .vec    (vec_ff),
         .half   (half_ff),
         .axis_ok(ok[g])
      );
   end

   // Drop the overlap flag if any axis shows a gap.
   always_ff @(posedge clock) begin
      if (en) begin
         overlap_ff <= &ok;
      end
   end

   assign rsp_valid   = vld_ff[DEPTH-1];
   assign rsp_overlap = overlap_ff;

   `ASSERT_HOLD(a_stall_freezes_valid, clock, reset, !en, vld_ff)
   `ASSERT_CLK(a_last_stage_delivers, clock, reset, en && vld_ff[DEPTH-2] |=> rsp_valid)
   `ASSERT_CLK(a_empty_stays_empty, clock, reset,
      en && !req_valid && vld_ff == '0 |=> vld_ff == '0 && !rsp_valid)
endmodule

`default_nettype wire

FILE: verif/obb_overlap_checker.sv
// Checker for the oriented-box overlap block: watches both channels, predicts each
// overlap bit with exact wide arithmetic and compares. Depends on nothing but its ports.
`default_nettype none

module obb_overlap_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [47:0] req_a_center,
   input  wire logic [47:0] req_a_axis_x,
   input  wire logic [47:0] req_a_axis_y,
   input  wire logic [47:0] req_a_axis_z,
   input  wire logic [46:0] req_a_half_size,
   input  wire logic [47:0] req_b_center,
   input  wire logic [47:0] req_b_axis_x,
   input  wire logic [47:0] req_b_axis_y,
   input  wire logic [47:0] req_b_axis_z,
   input  wire logic [46:0] req_b_half_size,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_overlap,
   output int               fail_count,
   output int               pending
);
   typedef logic signed [127:0] big_type;
   typedef big_type vec_type [3];
   typedef vec_type frame_type [3];

   bit overlap_q [$];

   function automatic big_type comp(input logic [47:0] w, input int k);
      comp = big_type'($signed(w[k*16 +: 16]));
   endfunction

   function automatic big_type abs_dot(input vec_type l, input vec_type v);
      big_type s;
      s = l[0]*v[0] + l[1]*v[1] + l[2]*v[2];
      abs_dot = (s < 0) ? -s : s;
   endfunction

   function automatic big_type reach(input vec_type l, input frame_type ax, input vec_type h);
      reach = h[0]*abs_dot(l, ax[0]) + h[1]*abs_dot(l, ax[1]) + h[2]*abs_dot(l, ax[2]);
   endfunction

   // One candidate axis: scaled centre distance against the summed projections.
   function automatic bit axis_ok(input vec_type l, input vec_type d, input frame_type a,
                                  input vec_type ha, input frame_type b, input vec_type hb);
      axis_ok = (abs_dot(l, d) * big_type'(1 << 14)) <= (reach(l, a, ha) + reach(l, b, hb));
   endfunction

   function automatic bit predict_overlap();
      frame_type a, b;
      vec_type d, ha, hb, l;
      bit ok;
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
         a[0][k] = comp(req_a_axis_x, k);
         a[1][k] = comp(req_a_axis_y, k);
         a[2][k] = comp(req_a_axis_z, k);
         b[0][k] = comp(req_b_axis_x, k);
         b[1][k] = comp(req_b_axis_y, k);
         b[2][k] = comp(req_b_axis_z, k);
         d[k]  = comp(req_b_center, k) - comp(req_a_center, k);
         // magnitude only: the top bit of each half length is dropped
         ha[k] = big_type'({1'b0, req_a_half_size[k*16 +: 15]});
         hb[k] = big_type'({1'b0, req_b_half_size[k*16 +: 15]});
      end
      for (int i = 0; i < 3; i++) begin
         if (!axis_ok(a[i], d, a, ha, b, hb)) ok = 1'b0;
         if (!axis_ok(b[i], d, a, ha, b, hb)) ok = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            l[0] = a[i][1]*b[j][2] - a[i][2]*b[j][1];
            l[1] = a[i][2]*b[j][0] - a[i][0]*b[j][2];
            l[2] = a[i][0]*b[j][1] - a[i][1]*b[j][0];
            if (!axis_ok(l, d, a, ha, b, hb)) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // Queue a prediction for each accepted word and check each returned word.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) overlap_q.push_back(predict_overlap());
         if (rsp_valid && !rsp_stall) begin
            if (overlap_q.size() == 0) begin
               $display("%0t: unexpected result word, overlap=%0b", $time, rsp_overlap);
               fail_count++;
            end else begin
               bit want;
               want = overlap_q.pop_front();
               if (rsp_overlap !== want) begin
                  $display("%0t: overlap expected %0b actual %0b", $time, want, rsp_overlap);
                  fail_count++;
               end
            end
         end
      end
      pending <= overlap_q.size();
   end

   final begin
   end
endmodule

`default_nettype wire

FILE: verif/obb_separating_axis_overlap_top_tb.sv
// Testbench top for the oriented-box overlap block: clock, reset, stimulus and verdict.
// Depends on obb_separating_axis_overlap_top and obb_overlap_checker.
`default_nettype none

module obb_separating_axis_overlap_top_tb;
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [47:0] a_center = '0, a_ax = '0, a_ay = '0, a_az = '0;
   logic [46:0] a_half = '0;
   logic [47:0] b_center = '0, b_ax = '0, b_ay = '0, b_az = '0;
   logic [46:0] b_half = '0;
   logic rsp_valid, rsp_overlap;
   logic rsp_stall = 1'b0;
   logic took = 1'b0;
   int fail_count, pending;
   int hold_left = 0;

   localparam logic [15:0] ONE = 16'h4000;
   localparam logic [47:0] UX = {16'h0, 16'h0, ONE};
   localparam logic [47:0] UY = {16'h0, ONE, 16'h0};
   localparam logic [47:0] UZ = {ONE, 16'h0, 16'h0};
   localparam logic [46:0] H1 = 47'({3{16'h0100}});

   always #5 clock = ~clock;

   obb_separating_axis_overlap_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_center(a_center), .req_a_axis_x(a_ax), .req_a_axis_y(a_ay),
      .req_a_axis_z(a_az), .req_a_half_size(a_half),
      .req_b_center(b_center), .req_b_axis_x(b_ax), .req_b_axis_y(b_ay),
      .req_b_axis_z(b_az), .req_b_half_size(b_half),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_overlap(rsp_overlap)
   );

   obb_overlap_checker u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_center(a_center), .req_a_axis_x(a_ax), .req_a_axis_y(a_ay),
      .req_a_axis_z(a_az), .req_a_half_size(a_half),
      .req_b_center(b_center), .req_b_axis_x(b_ax), .req_b_axis_y(b_ay),
      .req_b_axis_z(b_az), .req_b_half_size(b_half),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_overlap(rsp_overlap),
      .fail_count(fail_count), .pending(pending)
   );

   // Note acceptance at the edge so the driver can read it at the next falling edge.
   always @(posedge clock) begin
      took <= req_valid && !req_stall;
   end

   // Receiver stall: runs of free cycles and stalls, mostly short, now and then long.
   always @(negedge clock) begin
      if (hold_left == 0) begin
         if ($urandom_range(0, 99) < 55) begin
            rsp_stall <= 1'b0;
            hold_left <= $urandom_range(1, 20);
         end else begin
            rsp_stall <= 1'b1;
            hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                      : $urandom_range(1, 3);
         end
      end else begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   function automatic logic [15:0] rand_comp(input int span);
      return 16'($signed($urandom_range(0, 2*span)) - span);
   endfunction

   function automatic logic [47:0] rand_vec(input int span);
      return {rand_comp(span), rand_comp(span), rand_comp(span)};
   endfunction

   // Signed permutation of the unit axes, lightly perturbed now and then.
   function automatic logic [47:0] unit_axis(input int idx, input bit neg, input bit wobble);
      logic [47:0] v;
      v = '0;
      v[idx*16 +: 16] = neg ? -ONE : ONE;
      if (wobble) v = v + rand_vec(1500);
      return v;
   endfunction

   // Drive one word at the falling edge and hold it until it is taken.
   task automatic send_pair(input logic [47:0] ac, ax, ay, az, input logic [46:0] ah,
                            input logic [47:0] bc, bx, by, bz, input logic [46:0] bh);
      req_valid <= 1'b1;
      a_center <= ac; a_ax <= ax; a_ay <= ay; a_az <= az; a_half <= ah;
      b_center <= bc; b_ax <= bx; b_ay <= by; b_az <= bz; b_half <= bh;
      do @(negedge clock); while (!took);
   endtask

   task automatic idle_gap();
      int gap, roll;
      roll = $urandom_range(0, 99);
      gap = (roll < 60) ? 0 : (roll < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_framed(input bit wobble, input int cspan, input int hmax);
      int pa, pb;
      logic [46:0] ha, hb;
      pa = $urandom_range(0, 2);
      pb = $urandom_range(0, 2);
      ha = 47'({16'($urandom_range(0, hmax)), 16'($urandom_range(0, hmax)),
                16'($urandom_range(0, hmax))});
      hb = 47'({16'($urandom_range(0, hmax)), 16'($urandom_range(0, hmax)),
                16'($urandom_range(0, hmax))});
      send_pair(rand_vec(cspan), unit_axis(pa, 1'($urandom_range(0, 1)), wobble),
                unit_axis((pa + 1) % 3, 1'($urandom_range(0, 1)), wobble),
                unit_axis((pa + 2) % 3, 1'($urandom_range(0, 1)), wobble), ha,
                rand_vec(cspan), unit_axis(pb, 1'($urandom_range(0, 1)), wobble),
                unit_axis((pb + 2) % 3, 1'($urandom_range(0, 1)), wobble),
                unit_axis((pb + 1) % 3, 1'($urandom_range(0, 1)), wobble), hb);
   endtask

   initial begin
      fork
         begin
            repeat (10) @(negedge clock);
            reset <= 1'b0;
            @(negedge clock);

            // Directed: all zero, all ones, identical and distant boxes.
            send_pair('0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
            send_pair('1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
            send_pair('0, UX, UY, UZ, H1, '0, UX, UY, UZ, H1);
            send_pair({16'h8000, 16'h8000, 16'h8000}, UX, UY, UZ, H1,
                      {16'h7fff, 16'h7fff, 16'h7fff}, UX, UY, UZ, H1);
            // Just touching along x, then just apart.
            send_pair('0, UX, UY, UZ, H1, {32'h0, 16'h0200},
                      UX, UY, UZ, H1);
            send_pair('0, UX, UY, UZ, H1, {32'h0, 16'h0201},
                      UX, UY, UZ, H1);
            // Half-length sign bits set: only the magnitude counts.
            send_pair('0, UX, UY, UZ, {15'h7fff, 16'hffff, 16'h8001}, {32'h0, 16'h0200},
                      UX, UY, UZ, {15'h0, 16'h8000, 16'h8100});
            send_pair('0, UX, UY, UZ, 47'h7fff_7fff_7fff, {3{16'h7fff}},
                      UX, UY, UZ, 47'h7fff_7fff_7fff);
            // Parallel and zero axes give degenerate cross axes.
            send_pair('0, UX, UX, UX, H1, {16'h0, 16'h0300, 16'h0},
                      UX, UX, '0, H1);
            send_pair('0, '0, '0, '0, H1, {3{16'h0050}},
                      '0, '0, '0, H1);
            // Non-unit, extreme axes.
            send_pair({3{16'h8000}}, {3{16'h7fff}}, {3{16'h8000}}, {16'h7fff, 16'h8000, 16'h0},
                      47'h7fff_7fff_7fff, {3{16'h7fff}}, {3{16'h8000}}, {3{16'h7fff}},
                      {16'h8000, 16'h7fff, 16'h1}, 47'h7fff_7fff_7fff);
            // Rotated box B (45 degrees about z) near box A's corner.
            send_pair('0, UX, UY, UZ, H1, {16'h0, 16'h0280, 16'h0280},
                      {16'h0, 16'h2d41, 16'h2d41}, {16'h0, 16'h2d41, 16'hd2bf}, UZ,
                      H1);

            // Let the pipeline drain before the random part.
            req_valid <= 1'b0;
            while (pending != 0 || u_dut.rsp_valid === 1'bx) @(negedge clock);
            repeat (10) @(negedge clock);

            for (int n = 0; n < 400; n++) begin
               int roll;
               roll = $urandom_range(0, 99);
               if (n == 200) begin
                  req_valid <= 1'b0;
                  while (pending != 0) @(negedge clock);
                  repeat (10) @(negedge clock);
               end
               if (roll < 45) send_framed(1'b0, 1024, 1024);
               else if (roll < 80) send_framed(1'b1, 2048, 2048);
               else send_pair(rand48(), rand48(), rand48(), rand48(), 47'(rand48()),
                              rand48(), rand48(), rand48(), rand48(), 47'(rand48()));
               if ((n / 50) % 2 == 1) idle_gap();
            end
            req_valid <= 1'b0;

            while (pending != 0) @(negedge clock);
            repeat (20) @(negedge clock);
            if (fail_count == 0)
               $display("No mismatches found");
            else
               $display("Mismatches found");
            $finish;
         end
      join_none
   end

   // Give up if the run hangs.
   initial begin
      #20000000;
      $display("Mismatches found");
      $finish;
   end
endmodule

`default_nettype wire
